/* design/i2cm_pkg.sv */
// shared types and constants for the i2c master byte engine
package i2cm_pkg;

  localparam int unsigned HALF_W     = 16;
  localparam int unsigned POLL_W     = 8;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BIT_CNT_W  = 4;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [HALF_W-1:0]    HALF_RESET = HALF_W'(16);
  localparam logic [POLL_W-1:0]    POLL_RESET = POLL_W'(250);
  localparam logic [BIT_CNT_W-1:0] BIT_LIMIT  = BIT_CNT_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_PERIOD = 1'b0,
    CFG_ACK_POLL    = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_STOP  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_STOP,
    OP_WRITE,
    OP_READ
  } op_t;

  typedef enum logic [3:0] {
    P_IDLE,
    P_ST1,
    P_ST2,
    P_SP1,
    P_SP2,
    P_WLO,
    P_WHI,
    P_AKLO,
    P_AKHI,
    P_RLO,
    P_RHI,
    P_RALO,
    P_RAHI
  } phase_t;

  typedef struct packed {
    logic              cmd_valid;
    logic [1:0]        kind;
    logic [BYTE_W-1:0] tx_byte;
    logic              send_ack;
    logic              sda_in;
  } i2cm_in_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_pull_low;
    logic              cmd_ready;
    logic              cmd_done;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_missing;
    logic              timed_out;
  } i2cm_out_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] tx_byte;
    logic              send_ack;
    logic              sda_in;
  } i2cm_item_t;

endpackage

/* design/i2cm_front.sv */
// input stage: takes words and decodes the command into an operation
module i2cm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2cm_pkg::i2cm_in_t   in_data,
  output logic                 item_valid,
  input  logic                 item_ready,
  output i2cm_pkg::i2cm_item_t item
);

  logic                 valid_r;
  logic                 valid_nxt;
  i2cm_pkg::i2cm_item_t item_r;
  i2cm_pkg::i2cm_item_t item_nxt;
  logic                 take;

  assign in_ready   = !valid_r || item_ready;
  assign take       = in_valid && in_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    item_nxt.tx_byte  = in_data.tx_byte;
    item_nxt.send_ack = in_data.send_ack;
    item_nxt.sda_in   = in_data.sda_in;
    item_nxt.op       = i2cm_pkg::OP_NONE;
    if (in_data.cmd_valid) begin
      case (i2cm_pkg::kind_t'(in_data.kind))
        i2cm_pkg::KIND_START: item_nxt.op = i2cm_pkg::OP_START;
        i2cm_pkg::KIND_STOP:  item_nxt.op = i2cm_pkg::OP_STOP;
        i2cm_pkg::KIND_WRITE: item_nxt.op = i2cm_pkg::OP_WRITE;
        i2cm_pkg::KIND_READ:  item_nxt.op = i2cm_pkg::OP_READ;
        default:              item_nxt.op = i2cm_pkg::OP_NONE;
      endcase
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (item_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

endmodule

/* design/i2cm_fifo.sv */
// short queue of decoded words between front and back
module i2cm_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  i2cm_pkg::i2cm_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output i2cm_pkg::i2cm_item_t pop_item
);

  i2cm_pkg::i2cm_item_t                      mem_r [i2cm_pkg::FIFO_DEPTH];
  logic [i2cm_pkg::FIFO_PTR_W-1:0]           wr_ptr_r;
  logic [i2cm_pkg::FIFO_PTR_W-1:0]           wr_ptr_nxt;
  logic [i2cm_pkg::FIFO_PTR_W-1:0]           rd_ptr_r;
  logic [i2cm_pkg::FIFO_PTR_W-1:0]           rd_ptr_nxt;
  logic [i2cm_pkg::FIFO_CNT_W-1:0]           count_r;
  logic [i2cm_pkg::FIFO_CNT_W-1:0]           count_nxt;
  logic                                      push;
  logic                                      pop;

  localparam logic [i2cm_pkg::FIFO_PTR_W-1:0] PTR_LAST =
    i2cm_pkg::FIFO_PTR_W'(i2cm_pkg::FIFO_DEPTH - 1);
  localparam logic [i2cm_pkg::FIFO_CNT_W-1:0] CNT_FULL =
    i2cm_pkg::FIFO_CNT_W'(i2cm_pkg::FIFO_DEPTH);

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTH
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count beyond depth");
`endif

endmodule

/* design/i2cm_back.sv */
// bus engine: steps the scl/sda phase machine once per word and registers the result
module i2cm_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [i2cm_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  i2cm_pkg::i2cm_item_t                item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output i2cm_pkg::i2cm_out_t                 out_data
);

  logic [i2cm_pkg::HALF_W-1:0]    half_r;
  logic [i2cm_pkg::POLL_W-1:0]    limit_r;

  i2cm_pkg::phase_t               phase_r, phase_nxt;
  logic [i2cm_pkg::BIT_CNT_W-1:0] bit_r, bit_nxt;
  logic [i2cm_pkg::BYTE_W-1:0]    shift_r, shift_nxt;
  logic [i2cm_pkg::HALF_W-1:0]    tick_r, tick_nxt;
  logic [i2cm_pkg::POLL_W-1:0]    poll_r, poll_nxt;
  logic                           scl_r, scl_nxt;
  logic                           sda_r, sda_nxt;
  logic                           ack_r, ack_nxt;
  logic [1:0]                     flags_r, flags_nxt;
  logic [i2cm_pkg::BYTE_W-1:0]    rx_r, rx_nxt;

  logic                           out_valid_r, out_valid_nxt;
  i2cm_pkg::i2cm_out_t            out_data_r, result;

  logic                           step;
  logic                           done;
  logic                           do_enter;
  i2cm_pkg::phase_t               ent;
  logic [i2cm_pkg::HALF_W-1:0]    hp;
  logic [i2cm_pkg::HALF_W-1:0]    tick_inc;
  logic                           phase_end;

  assign item_ready = !out_valid_r || out_ready;
  assign step       = item_valid && item_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  assign hp        = (half_r == '0) ? i2cm_pkg::HALF_W'(1) : half_r;
  assign tick_inc  = tick_r + 1'b1;
  assign phase_end = (tick_inc >= hp);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r  <= i2cm_pkg::HALF_RESET;
      limit_r <= i2cm_pkg::POLL_RESET;
    end else if (cfg_we) begin
      if (cfg_index == i2cm_pkg::CFG_HALF_PERIOD) begin
        half_r <= cfg_wdata[i2cm_pkg::HALF_W-1:0];
      end else if (cfg_index == i2cm_pkg::CFG_ACK_POLL) begin
        limit_r <= cfg_wdata[i2cm_pkg::POLL_W-1:0];
      end
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    tick_nxt  = tick_r;
    poll_nxt  = poll_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    flags_nxt = flags_r;
    rx_nxt    = rx_r;
    done      = 1'b0;
    do_enter  = 1'b0;
    ent       = i2cm_pkg::P_IDLE;
    if (step) begin
      if (phase_r == i2cm_pkg::P_IDLE) begin
        if (item.op != i2cm_pkg::OP_NONE) begin
          bit_nxt  = '0;
          poll_nxt = '0;
          do_enter = 1'b1;
          case (item.op)
            i2cm_pkg::OP_START: ent = i2cm_pkg::P_ST1;
            i2cm_pkg::OP_STOP:  ent = i2cm_pkg::P_SP1;
            i2cm_pkg::OP_WRITE: begin
              shift_nxt = item.tx_byte;
              flags_nxt = 2'b00;
              ent       = i2cm_pkg::P_WLO;
            end
            i2cm_pkg::OP_READ: begin
              shift_nxt = '0;
              ack_nxt   = item.send_ack;
              ent       = i2cm_pkg::P_RLO;
            end
            default: do_enter = 1'b0;
          endcase
        end
      end else begin
        tick_nxt = tick_inc;
        if (phase_end) begin
          case (phase_r)
            i2cm_pkg::P_ST1: begin
              do_enter = 1'b1;
              ent      = i2cm_pkg::P_ST2;
            end
            i2cm_pkg::P_ST2: begin
              scl_nxt   = 1'b0;
              phase_nxt = i2cm_pkg::P_IDLE;
              done      = 1'b1;
            end
            i2cm_pkg::P_SP1: begin
              do_enter = 1'b1;
              ent      = i2cm_pkg::P_SP2;
            end
            i2cm_pkg::P_SP2: begin
              sda_nxt   = 1'b0;
              phase_nxt = i2cm_pkg::P_IDLE;
              done      = 1'b1;
            end
            i2cm_pkg::P_WLO: begin
              do_enter = 1'b1;
              ent      = i2cm_pkg::P_WHI;
            end
            i2cm_pkg::P_WHI: begin
              shift_nxt = {shift_r[i2cm_pkg::BYTE_W-2:0], 1'b0};
              bit_nxt   = bit_r + 1'b1;
              do_enter  = 1'b1;
              ent       = (bit_nxt >= i2cm_pkg::BIT_LIMIT) ? i2cm_pkg::P_AKLO
                                                           : i2cm_pkg::P_WLO;
            end
            i2cm_pkg::P_AKLO: begin
              poll_nxt = '0;
              do_enter = 1'b1;
              ent      = i2cm_pkg::P_AKHI;
            end
            i2cm_pkg::P_AKHI: begin
              if (!item.sda_in) begin
                scl_nxt   = 1'b0;
                phase_nxt = i2cm_pkg::P_IDLE;
                done      = 1'b1;
              end else if (poll_r >= limit_r) begin
                flags_nxt = 2'b11;
                do_enter  = 1'b1;
                ent       = i2cm_pkg::P_SP1;
              end else begin
                poll_nxt = poll_r + 1'b1;
                tick_nxt = '0;
              end
            end
            i2cm_pkg::P_RLO: begin
              do_enter = 1'b1;
              ent      = i2cm_pkg::P_RHI;
            end
            i2cm_pkg::P_RHI: begin
              shift_nxt = {shift_r[i2cm_pkg::BYTE_W-2:0], item.sda_in};
              bit_nxt   = bit_r + 1'b1;
              do_enter  = 1'b1;
              ent       = (bit_nxt >= i2cm_pkg::BIT_LIMIT) ? i2cm_pkg::P_RALO
                                                           : i2cm_pkg::P_RLO;
            end
            i2cm_pkg::P_RALO: begin
              do_enter = 1'b1;
              ent      = i2cm_pkg::P_RAHI;
            end
            i2cm_pkg::P_RAHI: begin
              scl_nxt   = 1'b0;
              rx_nxt    = shift_r;
              phase_nxt = i2cm_pkg::P_IDLE;
              done      = 1'b1;
            end
            default: phase_nxt = i2cm_pkg::P_IDLE;
          endcase
        end
      end
    end
    // levels driven on entry to a half phase
    if (do_enter) begin
      phase_nxt = ent;
      tick_nxt  = '0;
      case (ent)
        i2cm_pkg::P_ST1: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b0;
        end
        i2cm_pkg::P_ST2, i2cm_pkg::P_SP2: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
        end
        i2cm_pkg::P_SP1: begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b1;
        end
        i2cm_pkg::P_WLO: begin
          scl_nxt = 1'b0;
          sda_nxt = !shift_nxt[i2cm_pkg::BYTE_W-1];
        end
        i2cm_pkg::P_AKLO, i2cm_pkg::P_RLO: begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b0;
        end
        i2cm_pkg::P_RALO: begin
          scl_nxt = 1'b0;
          sda_nxt = ack_nxt;
        end
        i2cm_pkg::P_WHI, i2cm_pkg::P_AKHI, i2cm_pkg::P_RHI, i2cm_pkg::P_RAHI: begin
          scl_nxt = 1'b1;
        end
        default: begin
          scl_nxt = scl_nxt;
        end
      endcase
    end
  end

  // result word
  always_comb begin
    result.scl_level    = scl_nxt;
    result.sda_pull_low = sda_nxt;
    result.cmd_ready    = (phase_nxt == i2cm_pkg::P_IDLE);
    result.cmd_done     = done;
    result.rx_byte      = rx_nxt;
    result.ack_missing  = flags_nxt[0];
    result.timed_out    = flags_nxt[1];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= i2cm_pkg::P_IDLE;
      bit_r       <= '0;
      shift_r     <= '0;
      tick_r      <= '0;
      poll_r      <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b0;
      ack_r       <= 1'b0;
      flags_r     <= 2'b00;
      rx_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      bit_r       <= bit_nxt;
      shift_r     <= shift_nxt;
      tick_r      <= tick_nxt;
      poll_r      <= poll_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      ack_r       <= ack_nxt;
      flags_r     <= flags_nxt;
      rx_r        <= rx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

`ifndef SYNTH
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= i2cm_pkg::BIT_LIMIT)
    else $error("bit count past a byte");
`endif

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && done) |=> (phase_r == i2cm_pkg::P_IDLE))
    else $error("command done but engine not idle");
`endif

`ifndef SYNTH
  a_scl_high: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == i2cm_pkg::P_ST1 || phase_r == i2cm_pkg::P_ST2 ||
     phase_r == i2cm_pkg::P_SP2 || phase_r == i2cm_pkg::P_WHI ||
     phase_r == i2cm_pkg::P_AKHI || phase_r == i2cm_pkg::P_RHI ||
     phase_r == i2cm_pkg::P_RAHI) |-> scl_r)
    else $error("scl low in a high half phase");
`endif

endmodule

/* design/i2c_master_byte_engine.sv */
// top level of the i2c master byte engine: front stage, queue and bus engine
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_ready  | in_data   (one tick word)
//   out     | output    | out_valid/out_ready| out_data  (one result word)
//   cfg     | input     | cfg_we             | cfg_index, cfg_wdata
//
// one word per cycle sustained while out_ready stays high, as the bus engine steps its phase machine once per word
// after accept a word is registered in the front register, the queue and the result register
// reset is synchronous: divider 16, poll limit 250, bus idle with scl high and sda released
// a stalled out channel fills the result register, then the two-entry queue, then the
// front register, and only then drops in_ready
module i2c_master_byte_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  i2cm_pkg::i2cm_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output i2cm_pkg::i2cm_out_t            out_data,
  input  logic                           cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [i2cm_pkg::CFG_W-1:0]     cfg_wdata
);

  logic                 fr_valid;
  logic                 fr_ready;
  i2cm_pkg::i2cm_item_t fr_item;
  logic                 q_valid;
  logic                 q_ready;
  i2cm_pkg::i2cm_item_t q_item;

  i2cm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (fr_valid),
    .item_ready (fr_ready),
    .item       (fr_item)
  );

  i2cm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  i2cm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

/* test/tb_top.sv */
// self-checking testbench for the i2c master byte engine with a tick-level bus predictor
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 200000;

  localparam i2cm_pkg::i2cm_out_t IDLE_OUT = '{
    scl_level: 1'b1, sda_pull_low: 1'b0, cmd_ready: 1'b1, cmd_done: 1'b0,
    rx_byte: 8'h00, ack_missing: 1'b0, timed_out: 1'b0};

  typedef struct {
    i2cm_pkg::i2cm_in_t  word;
    int unsigned         reps;
    bit                  typed;
    i2cm_pkg::i2cm_out_t want;
  } tick_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  i2cm_pkg::i2cm_in_t             in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b1;
  i2cm_pkg::i2cm_out_t            out_data;
  logic                           cfg_we = 1'b0;
  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [i2cm_pkg::CFG_W-1:0]     cfg_wdata = '0;

  i2c_master_byte_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // bus engine copy
  i2cm_pkg::phase_t                bus_phase = i2cm_pkg::P_IDLE;
  logic [i2cm_pkg::BIT_CNT_W-1:0]  bit_cnt = '0;
  logic [i2cm_pkg::BYTE_W-1:0]     shifter = '0;
  logic [i2cm_pkg::HALF_W-1:0]     tick_cnt = '0;
  logic [i2cm_pkg::POLL_W-1:0]     poll_cnt = '0;
  logic                            scl_q = 1'b1;
  logic                            sda_low_q = 1'b0;
  logic                            ack_sel = 1'b0;
  logic [1:0]                      flags = '0;
  logic [i2cm_pkg::BYTE_W-1:0]     rx_last = '0;
  logic [i2cm_pkg::HALF_W-1:0]     half_cfg = i2cm_pkg::HALF_RESET;
  logic [i2cm_pkg::POLL_W-1:0]     poll_cfg = i2cm_pkg::POLL_RESET;

  i2cm_pkg::i2cm_out_t   bus_words_q [$];
  int unsigned           err_cnt = 0;
  int unsigned           cyc_cnt = 0;
  int unsigned           stall_left = 0;
  bit                    gap_on = 1'b1;
  tick_row_t             dir_tab [14];

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else if (gap_on && rst_n && $urandom_range(0, 5) == 0) begin
      out_ready = 1'b0;
      stall_left = $urandom_range(1, 3) - 1;
    end else begin
      out_ready = 1'b1;
    end
  end

  function automatic void enter_phase(i2cm_pkg::phase_t p);
    bus_phase = p;
    tick_cnt = '0;
    case (p)
      i2cm_pkg::P_ST1: begin
        scl_q = 1'b1;
        sda_low_q = 1'b0;
      end
      i2cm_pkg::P_ST2, i2cm_pkg::P_SP2: begin
        scl_q = 1'b1;
        sda_low_q = 1'b1;
      end
      i2cm_pkg::P_SP1: begin
        scl_q = 1'b0;
        sda_low_q = 1'b1;
      end
      i2cm_pkg::P_WLO: begin
        scl_q = 1'b0;
        sda_low_q = ~shifter[i2cm_pkg::BYTE_W-1];
      end
      i2cm_pkg::P_AKLO, i2cm_pkg::P_RLO: begin
        scl_q = 1'b0;
        sda_low_q = 1'b0;
      end
      i2cm_pkg::P_RALO: begin
        scl_q = 1'b0;
        sda_low_q = ack_sel;
      end
      i2cm_pkg::P_WHI, i2cm_pkg::P_AKHI, i2cm_pkg::P_RHI, i2cm_pkg::P_RAHI: scl_q = 1'b1;
      default: ;
    endcase
  endfunction

  function automatic i2cm_pkg::i2cm_out_t bus_tick(i2cm_pkg::i2cm_in_t w);
    logic [i2cm_pkg::HALF_W-1:0] hp;
    logic                        done;
    i2cm_pkg::i2cm_out_t         r;
    hp = (half_cfg == '0) ? i2cm_pkg::HALF_W'(1) : half_cfg;
    done = 1'b0;
    if (bus_phase == i2cm_pkg::P_IDLE) begin
      if (w.cmd_valid) begin
        bit_cnt = '0;
        poll_cnt = '0;
        case (i2cm_pkg::kind_t'(w.kind))
          i2cm_pkg::KIND_START: enter_phase(i2cm_pkg::P_ST1);
          i2cm_pkg::KIND_STOP: enter_phase(i2cm_pkg::P_SP1);
          i2cm_pkg::KIND_WRITE: begin
            shifter = w.tx_byte;
            flags = '0;
            enter_phase(i2cm_pkg::P_WLO);
          end
          default: begin
            shifter = '0;
            ack_sel = w.send_ack;
            enter_phase(i2cm_pkg::P_RLO);
          end
        endcase
      end
    end else begin
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= hp) begin
        case (bus_phase)
          i2cm_pkg::P_ST1: enter_phase(i2cm_pkg::P_ST2);
          i2cm_pkg::P_ST2: begin
            scl_q = 1'b0;
            bus_phase = i2cm_pkg::P_IDLE;
            done = 1'b1;
          end
          i2cm_pkg::P_SP1: enter_phase(i2cm_pkg::P_SP2);
          i2cm_pkg::P_SP2: begin
            sda_low_q = 1'b0;
            bus_phase = i2cm_pkg::P_IDLE;
            done = 1'b1;
          end
          i2cm_pkg::P_WLO: enter_phase(i2cm_pkg::P_WHI);
          i2cm_pkg::P_WHI: begin
            shifter = shifter << 1;
            bit_cnt = bit_cnt + 1'b1;
            enter_phase((bit_cnt >= i2cm_pkg::BIT_LIMIT) ? i2cm_pkg::P_AKLO
                                                         : i2cm_pkg::P_WLO);
          end
          i2cm_pkg::P_AKLO: begin
            poll_cnt = '0;
            enter_phase(i2cm_pkg::P_AKHI);
          end
          i2cm_pkg::P_AKHI: begin
            if (!w.sda_in) begin
              scl_q = 1'b0;
              bus_phase = i2cm_pkg::P_IDLE;
              done = 1'b1;
            end else if (poll_cnt >= poll_cfg) begin
              flags = 2'b11;
              enter_phase(i2cm_pkg::P_SP1);
            end else begin
              poll_cnt = poll_cnt + 1'b1;
              tick_cnt = '0;
            end
          end
          i2cm_pkg::P_RLO: enter_phase(i2cm_pkg::P_RHI);
          i2cm_pkg::P_RHI: begin
            shifter = {shifter[i2cm_pkg::BYTE_W-2:0], w.sda_in};
            bit_cnt = bit_cnt + 1'b1;
            enter_phase((bit_cnt >= i2cm_pkg::BIT_LIMIT) ? i2cm_pkg::P_RALO
                                                         : i2cm_pkg::P_RLO);
          end
          i2cm_pkg::P_RALO: enter_phase(i2cm_pkg::P_RAHI);
          i2cm_pkg::P_RAHI: begin
            scl_q = 1'b0;
            rx_last = shifter;
            bus_phase = i2cm_pkg::P_IDLE;
            done = 1'b1;
          end
          default: bus_phase = i2cm_pkg::P_IDLE;
        endcase
      end
    end
    r.scl_level = scl_q;
    r.sda_pull_low = sda_low_q;
    r.cmd_ready = (bus_phase == i2cm_pkg::P_IDLE);
    r.cmd_done = done;
    r.rx_byte = rx_last;
    r.ack_missing = flags[0];
    r.timed_out = flags[1];
    return r;
  endfunction

  function automatic i2cm_pkg::i2cm_in_t rand_tick(bit force_write, int unsigned sda_hi_pct);
    i2cm_pkg::i2cm_in_t w;
    if (bus_phase == i2cm_pkg::P_IDLE) begin
      w.cmd_valid = ($urandom_range(0, 3) != 0);
    end else begin
      w.cmd_valid = 1'($urandom_range(0, 1));
    end
    w.kind = force_write ? i2cm_pkg::KIND_WRITE : i2cm_pkg::kind_t'($urandom_range(0, 3));
    w.tx_byte = 8'($urandom_range(0, 255));
    w.send_ack = 1'($urandom_range(0, 1));
    w.sda_in = ($urandom_range(0, 99) < sda_hi_pct);
    return w;
  endfunction

  task automatic send_tick(input i2cm_pkg::i2cm_in_t w, input bit typed,
                           input i2cm_pkg::i2cm_out_t want);
    i2cm_pkg::i2cm_out_t pred;
    if (gap_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = bus_tick(w);
    bus_words_q.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (bus_words_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_reg(input i2cm_pkg::cfg_idx_t idx,
                         input logic [i2cm_pkg::CFG_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == i2cm_pkg::CFG_HALF_PERIOD) begin
      half_cfg = val;
    end else begin
      poll_cfg = val[i2cm_pkg::POLL_W-1:0];
    end
  endtask

  task automatic run_random(input logic [i2cm_pkg::CFG_W-1:0] hp,
                            input logic [i2cm_pkg::CFG_W-1:0] polls,
                            input int unsigned n, input int unsigned sda_hi_pct,
                            input bit force_write);
    settle();
    set_reg(i2cm_pkg::CFG_HALF_PERIOD, hp);
    set_reg(i2cm_pkg::CFG_ACK_POLL, polls);
    repeat (n) send_tick(rand_tick(force_write, sda_hi_pct), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    i2cm_pkg::i2cm_out_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (bus_words_q.size() == 0) begin
        $error("unexpected result word %h", out_data);
        err_cnt++;
      end else begin
        exp_w = bus_words_q.pop_front();
        if (out_data.scl_level !== exp_w.scl_level) begin
          $error("scl_level exp %0h got %0h", exp_w.scl_level, out_data.scl_level);
          err_cnt++;
        end
        if (out_data.sda_pull_low !== exp_w.sda_pull_low) begin
          $error("sda_pull_low exp %0h got %0h", exp_w.sda_pull_low, out_data.sda_pull_low);
          err_cnt++;
        end
        if (out_data.cmd_ready !== exp_w.cmd_ready) begin
          $error("cmd_ready exp %0h got %0h", exp_w.cmd_ready, out_data.cmd_ready);
          err_cnt++;
        end
        if (out_data.cmd_done !== exp_w.cmd_done) begin
          $error("cmd_done exp %0h got %0h", exp_w.cmd_done, out_data.cmd_done);
          err_cnt++;
        end
        if (out_data.rx_byte !== exp_w.rx_byte) begin
          $error("rx_byte exp %0h got %0h", exp_w.rx_byte, out_data.rx_byte);
          err_cnt++;
        end
        if (out_data.ack_missing !== exp_w.ack_missing) begin
          $error("ack_missing exp %0h got %0h", exp_w.ack_missing, out_data.ack_missing);
          err_cnt++;
        end
        if (out_data.timed_out !== exp_w.timed_out) begin
          $error("timed_out exp %0h got %0h", exp_w.timed_out, out_data.timed_out);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    dir_tab = '{
      '{'{1'b0, i2cm_pkg::KIND_START, 8'h00, 1'b0, 1'b0}, 2,  1'b1, IDLE_OUT},
      '{'{1'b1, i2cm_pkg::KIND_START, 8'h00, 1'b0, 1'b0}, 1,  1'b0, '0},
      '{'{1'b1, i2cm_pkg::KIND_STOP,  8'h00, 1'b0, 1'b0}, 1,  1'b0, '0},
      '{'{1'b0, i2cm_pkg::KIND_START, 8'h00, 1'b0, 1'b0}, 2,  1'b0, '0},
      '{'{1'b1, i2cm_pkg::KIND_STOP,  8'h00, 1'b0, 1'b0}, 1,  1'b0, '0},
      '{'{1'b0, i2cm_pkg::KIND_START, 8'h00, 1'b0, 1'b0}, 3,  1'b0, '0},
      '{'{1'b1, i2cm_pkg::KIND_WRITE, 8'hFF, 1'b0, 1'b0}, 1,  1'b0, '0},
      '{'{1'b0, i2cm_pkg::KIND_WRITE, 8'h00, 1'b0, 1'b0}, 19, 1'b0, '0},
      '{'{1'b1, i2cm_pkg::KIND_WRITE, 8'h00, 1'b0, 1'b1}, 1,  1'b0, '0},
      '{'{1'b0, i2cm_pkg::KIND_WRITE, 8'h00, 1'b0, 1'b1}, 22, 1'b0, '0},
      '{'{1'b1, i2cm_pkg::KIND_READ,  8'hFF, 1'b1, 1'b1}, 1,  1'b0, '0},
      '{'{1'b0, i2cm_pkg::KIND_READ,  8'h00, 1'b0, 1'b1}, 20, 1'b0, '0},
      '{'{1'b1, i2cm_pkg::KIND_READ,  8'h00, 1'b0, 1'b0}, 1,  1'b0, '0},
      '{'{1'b0, i2cm_pkg::KIND_READ,  8'h00, 1'b0, 1'b0}, 20, 1'b0, '0}
    };
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // zero divider behaves as one, zero poll limit times out on the first high sample
    set_reg(i2cm_pkg::CFG_HALF_PERIOD, 16'd0);
    set_reg(i2cm_pkg::CFG_ACK_POLL, 16'd0);
    foreach (dir_tab[i]) begin
      repeat (dir_tab[i].reps) send_tick(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].want);
    end

    run_random(16'd1, 16'd3, 50, 50, 1'b0);
    run_random(16'd2, 16'd0, 40, 85, 1'b0);
    run_random(16'd3, 16'd255, 30, 50, 1'b0);
    run_random(16'd65535, 16'd1, 15, 50, 1'b0);
    run_random(16'd1, 16'd24, 60, 100, 1'b1);
    run_random(16'($urandom_range(1, 4)), 16'($urandom_range(0, 4)), 40, 70, 1'b0);
    run_random(16'd0, 16'd2, 20, 50, 1'b0);

    // last stretch without idling on either side
    settle();
    gap_on = 1'b0;
    run_random(16'd1, 16'd1, 50, 60, 1'b0);
    settle();

    if (err_cnt == 0 && bus_words_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
design/i2cm_pkg.sv
design/i2cm_front.sv
design/i2cm_fifo.sv
design/i2cm_back.sv
design/i2c_master_byte_engine.sv
test/tb_top.sv
